// ===== hdl/lhr_pkg.sv =====
// shared types, constants and helpers of the line history ring
// depends on nothing; imported by lhr_dp, lhr_ctrl and the top level
package lhr_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int LINE_BYTES = 64;

  localparam int SLOT_W    = $clog2(HIST_DEPTH);
  localparam int CNT_W     = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W     = $clog2(LINE_BYTES);
  localparam int SUM_W     = CNT_W + 2;
  localparam int ENT_AW    = SLOT_W + IDX_W;
  localparam int ENT_WORDS = HIST_DEPTH * (2 ** IDX_W);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_PREV   = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
    logic       no_line;
  } out_t;

  typedef enum logic [1:0] {
    OUT_ENT   = 2'd0,
    OUT_SCR   = 2'd1,
    OUT_NONE  = 2'd2,
    OUT_EMPTY = 2'd3
  } out_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_NEXT,
    ST_CPE_RD,
    ST_CPE_WR,
    ST_CPS_RD,
    ST_CPS_WR,
    ST_EME_RD,
    ST_EME_LD,
    ST_EMS_RD,
    ST_EMS_LD,
    ST_NONE,
    ST_EMPTY
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic     accept;
    logic     ent_re;
    logic     ent_rd_browse;
    logic     ent_we;
    logic     stg_re;
    logic     scr_re;
    logic     scr_we;
    logic     stage;
    logic     clear_stg;
    logic     push_commit;
    logic     browse_start;
    logic     browse_back;
    logic     browse_fwd;
    logic     browse_stop;
    logic     cancel;
    logic     idx_clr;
    logic     idx_inc;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic byte_zero;
    logic kind_prev;
    logic line_empty;
    logic dup;
    logic hist_empty;
    logic browsing;
    logic at_newest;
    logic scr_present;
    logic copy_last;
    logic ent_term;
    logic scr_term;
    logic out_free;
  } sts_t;

  function automatic slot_t newest_slot(slot_t next, cnt_t count);
    logic [SUM_W-1:0] s;
    s = SUM_W'(next) + SUM_W'(count) + SUM_W'(HIST_DEPTH - 1);
    if (s >= SUM_W'(HIST_DEPTH)) s = s - SUM_W'(HIST_DEPTH);
    if (s >= SUM_W'(HIST_DEPTH)) s = s - SUM_W'(HIST_DEPTH);
    return s[SLOT_W-1:0];
  endfunction

  function automatic slot_t slot_inc(slot_t s);
    return (s == SLOT_W'(HIST_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    return (s == '0) ? SLOT_W'(HIST_DEPTH - 1) : s - SLOT_W'(1);
  endfunction

endpackage

// ===== hdl/lhr_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// self-contained, no package needed
module lhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lhr_dp.sv =====
// datapath: line memories, history pointers, staging state and output register
// depends on lhr_pkg and lhr_ram
module lhr_dp
  import lhr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cnt_t       count_q, count_d;
  slot_t      next_q, next_d;
  slot_t      browse_q, browse_d;
  logic       browsing_q, browsing_d;
  logic       scr_pres_q, scr_pres_d;
  idx_t       len_q, len_d;
  logic       overlong_q, overlong_d;
  logic       match_q, match_d;
  idx_t       idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic [7:0] byte_q;
  kind_e      kind_q;

  slot_t       newest;
  slot_t       oldest;
  logic        len_full;
  logic [7:0]  ent_rdata, stg_rdata, scr_rdata;
  logic [7:0]  copy_data;
  logic [ENT_AW-1:0] ent_raddr;

  assign newest    = newest_slot(next_q, count_q);
  assign oldest    = (count_q == CNT_W'(HIST_DEPTH)) ? next_q : '0;
  assign len_full  = (len_q == IDX_W'(LINE_BYTES - 1));
  assign copy_data = (idx_q == len_q) ? 8'h00 : stg_rdata;
  assign ent_raddr = cmd_i.ent_rd_browse ? {browse_q, idx_q} : {newest, len_q};

  lhr_ram #(.WIDTH(8), .DEPTH(ENT_WORDS)) u_entry (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ent_we),
    .waddr_i ({next_q, idx_q}),
    .wdata_i (copy_data),
    .re_i    (cmd_i.ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  lhr_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_staging (
    .clk_i   (clk_i),
    .we_i    (cmd_i.stage && !len_full),
    .waddr_i (len_q),
    .wdata_i (byte_q),
    .re_i    (cmd_i.stg_re),
    .raddr_i (idx_q),
    .rdata_o (stg_rdata)
  );

  lhr_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (cmd_i.scr_we),
    .waddr_i (idx_q),
    .wdata_i (copy_data),
    .re_i    (cmd_i.scr_re),
    .raddr_i (idx_q),
    .rdata_o (scr_rdata)
  );

  always_comb begin
    count_d    = count_q;
    next_d     = next_q;
    browse_d   = browse_q;
    browsing_d = browsing_q;
    scr_pres_d = scr_pres_q;
    len_d      = len_q;
    overlong_d = overlong_q;
    match_d    = match_q;
    idx_d      = idx_q;

    if (cmd_i.stage) begin
      if (len_full) begin
        overlong_d = 1'b1;
      end else begin
        len_d = len_q + IDX_W'(1);
        if (match_q && (count_q != '0) && (ent_rdata != byte_q)) begin
          match_d = 1'b0;
        end
      end
    end
    if (cmd_i.clear_stg) begin
      len_d      = '0;
      overlong_d = 1'b0;
      match_d    = 1'b1;
    end
    if (cmd_i.push_commit) begin
      next_d     = slot_inc(next_q);
      browsing_d = 1'b0;
      scr_pres_d = 1'b0;
      if (count_q != CNT_W'(HIST_DEPTH)) begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.browse_start) begin
      browse_d   = newest;
      browsing_d = 1'b1;
      scr_pres_d = 1'b1;
    end
    if (cmd_i.browse_back && (browse_q != oldest)) begin
      browse_d = slot_dec(browse_q);
    end
    if (cmd_i.browse_fwd) begin
      browse_d = slot_inc(browse_q);
    end
    if (cmd_i.browse_stop) begin
      browsing_d = 1'b0;
    end
    if (cmd_i.cancel) begin
      browsing_d = 1'b0;
      scr_pres_d = 1'b0;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      case (cmd_i.out_sel)
        OUT_ENT: begin
          out_d.out_byte = sts_o.ent_term ? 8'h00 : ent_rdata;
          out_d.line_end = sts_o.ent_term;
          out_d.no_line  = 1'b0;
        end
        OUT_SCR: begin
          out_d.out_byte = sts_o.scr_term ? 8'h00 : scr_rdata;
          out_d.line_end = sts_o.scr_term;
          out_d.no_line  = 1'b0;
        end
        OUT_NONE: begin
          out_d.out_byte = 8'h00;
          out_d.line_end = 1'b0;
          out_d.no_line  = 1'b1;
        end
        OUT_EMPTY: begin
          out_d.out_byte = 8'h00;
          out_d.line_end = 1'b1;
          out_d.no_line  = 1'b0;
        end
        default: begin
          out_d = out_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      next_q      <= '0;
      browse_q    <= '0;
      browsing_q  <= 1'b0;
      scr_pres_q  <= 1'b0;
      len_q       <= '0;
      overlong_q  <= 1'b0;
      match_q     <= 1'b1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      next_q      <= next_d;
      browse_q    <= browse_d;
      browsing_q  <= browsing_d;
      scr_pres_q  <= scr_pres_d;
      len_q       <= len_d;
      overlong_q  <= overlong_d;
      match_q     <= match_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.accept) begin
      byte_q <= in_data_i.char_byte;
      kind_q <= in_data_i.kind;
    end
  end

  always_comb begin
    sts_o.byte_zero   = (byte_q == 8'h00);
    sts_o.kind_prev   = (kind_q == KIND_PREV);
    sts_o.line_empty  = (len_q == '0) && !overlong_q;
    sts_o.dup         = (count_q != '0) && match_q && !overlong_q && (ent_rdata == 8'h00);
    sts_o.hist_empty  = (count_q == '0);
    sts_o.browsing    = browsing_q;
    sts_o.at_newest   = (browse_q == newest);
    sts_o.scr_present = scr_pres_q;
    sts_o.copy_last   = (idx_q == len_q);
    sts_o.ent_term    = (ent_rdata == 8'h00) || (idx_q == IDX_W'(LINE_BYTES - 1));
    sts_o.scr_term    = (scr_rdata == 8'h00) || (idx_q == IDX_W'(LINE_BYTES - 1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/lhr_ctrl.sv =====
// controller state machine: sequences staging, line copies and line replay
// depends on lhr_pkg
module lhr_ctrl
  import lhr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  kind_e in_kind_i,
  output logic  in_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_NEXT) begin
            state_d = ST_NEXT;
          end else if (in_kind_i != KIND_CANCEL) begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (!sts_i.byte_zero) begin
          state_d = ST_IDLE;
        end else if (!sts_i.kind_prev) begin
          state_d = (sts_i.line_empty || sts_i.dup) ? ST_IDLE : ST_CPE_RD;
        end else if (sts_i.hist_empty) begin
          state_d = ST_NONE;
        end else if (!sts_i.browsing) begin
          state_d = ST_CPS_RD;
        end else begin
          state_d = ST_EME_RD;
        end
      end
      ST_NEXT: begin
        if (!sts_i.browsing) begin
          state_d = ST_NONE;
        end else if (!sts_i.at_newest) begin
          state_d = ST_EME_RD;
        end else begin
          state_d = sts_i.scr_present ? ST_EMS_RD : ST_EMPTY;
        end
      end
      ST_CPE_RD: state_d = ST_CPE_WR;
      ST_CPE_WR: state_d = sts_i.copy_last ? ST_IDLE : ST_CPE_RD;
      ST_CPS_RD: state_d = ST_CPS_WR;
      ST_CPS_WR: state_d = sts_i.copy_last ? ST_EME_RD : ST_CPS_RD;
      ST_EME_RD: state_d = ST_EME_LD;
      ST_EME_LD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.ent_term ? ST_IDLE : ST_EME_RD;
        end
      end
      ST_EMS_RD: state_d = ST_EMS_LD;
      ST_EMS_LD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.scr_term ? ST_IDLE : ST_EMS_RD;
        end
      end
      ST_NONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.out_sel = OUT_ENT;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        // look up the newest entry at the staging position for the match check
        cmd_o.ent_re = in_valid_i;
        cmd_o.cancel = in_valid_i && (in_kind_i == KIND_CANCEL);
      end
      ST_EVAL: begin
        if (!sts_i.byte_zero) begin
          cmd_o.stage = 1'b1;
        end else if (!sts_i.kind_prev) begin
          cmd_o.clear_stg = sts_i.line_empty || sts_i.dup;
          cmd_o.idx_clr   = 1'b1;
        end else if (sts_i.hist_empty) begin
          cmd_o.clear_stg = 1'b1;
        end else if (!sts_i.browsing) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.browse_back = 1'b1;
          cmd_o.clear_stg   = 1'b1;
          cmd_o.idx_clr     = 1'b1;
        end
      end
      ST_NEXT: begin
        cmd_o.idx_clr = 1'b1;
        if (sts_i.browsing) begin
          if (sts_i.at_newest) begin
            cmd_o.browse_stop = 1'b1;
          end else begin
            cmd_o.browse_fwd = 1'b1;
          end
        end
      end
      ST_CPE_RD: cmd_o.stg_re = 1'b1;
      ST_CPE_WR: begin
        cmd_o.ent_we = 1'b1;
        if (sts_i.copy_last) begin
          cmd_o.push_commit = 1'b1;
          cmd_o.clear_stg   = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_CPS_RD: cmd_o.stg_re = 1'b1;
      ST_CPS_WR: begin
        cmd_o.scr_we = 1'b1;
        if (sts_i.copy_last) begin
          cmd_o.browse_start = 1'b1;
          cmd_o.clear_stg    = 1'b1;
          cmd_o.idx_clr      = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_EME_RD: begin
        cmd_o.ent_re        = 1'b1;
        cmd_o.ent_rd_browse = 1'b1;
      end
      ST_EME_LD: begin
        cmd_o.out_sel  = OUT_ENT;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.idx_inc  = sts_i.out_free && !sts_i.ent_term;
      end
      ST_EMS_RD: cmd_o.scr_re = 1'b1;
      ST_EMS_LD: begin
        cmd_o.out_sel  = OUT_SCR;
        cmd_o.out_load = sts_i.out_free;
        cmd_o.idx_inc  = sts_i.out_free && !sts_i.scr_term;
      end
      ST_NONE: begin
        cmd_o.out_sel  = OUT_NONE;
        cmd_o.out_load = sts_i.out_free;
      end
      ST_EMPTY: begin
        cmd_o.out_sel  = OUT_EMPTY;
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/line_history_ring_unit.sv =====
// top level of the line history ring: controller plus datapath
// depends on lhr_pkg, lhr_ctrl, lhr_dp (and lhr_ram below it)
//
// usage
// - input channel (in_valid_i/in_ready_o/in_data_i) carries one byte or command
//   per transaction: push byte, prev byte, next, cancel; a zero byte ends a line
// - output channel (out_valid_o/out_ready_i/out_data_o) returns lines one byte
//   per transaction, closed by a zero byte with line_end set, or a single
//   transaction with no_line set when there is nothing to return
// - one transaction is handled at a time; a non-terminating byte is accepted
//   and then staged from the EVAL state, a cancel is handled in its accept cycle only
// - pushing a stored line walks the staging memory, one byte copied at a time
//   through the staging read port: a staging read, then an entry memory write
// - replay returns each byte by an entry or scratch memory read, then an
//   output register load; starting to browse first copies the current line to
//   scratch, a staging read then a scratch write per byte
// - a stalled receiver only holds the output register; the controller waits
//   for it before loading the next returned byte, and it can take a new input
//   transaction while the last returned byte is still waiting
// - reset empties the history and ends browsing; the line memories are not
//   cleared and need no clearing pass
module line_history_ring_unit
  import lhr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing of each transaction
  lhr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // line memories, pointers and the output register
  lhr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
